@@ rtl/core/lin_rx_pkg.sv @@
// Shared types, constants and helpers for the LIN slave frame receiver.
`default_nettype none

package lin_rx_pkg;

   // Receive sequencer phases
   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_BREAK = 3'd1,
      PH_SYNC  = 3'd2,
      PH_ID    = 3'd3,
      PH_DATA  = 3'd4
   } phase_type;

   localparam int          FRAME_LEN_DEFAULT = 4;
   localparam logic [7:0]  SYNC_BYTE         = 8'h55;

   // Register map (word index) and reset values
   localparam int          CSR_ADDR_W     = 4;
   localparam logic [1:0]  REG_RESPONSE_ID = 2'd0;
   localparam logic [1:0]  REG_FIXTURE_ID  = 2'd1;
   localparam logic [1:0]  REG_PATTERN_A   = 2'd2;
   localparam logic [1:0]  REG_PATTERN_B   = 2'd3;

   localparam logic [7:0]  RESPONSE_ID_RST = 8'h2E;
   localparam logic [7:0]  FIXTURE_ID_RST  = 8'h42;
   localparam logic [31:0] PATTERN_A_RST   = 32'hD344_FFBB;
   localparam logic [31:0] PATTERN_B_RST   = 32'h14FD_FF02;

   // Byte i of a pattern, identifier in the top byte; bytes past the fourth are zero
   function automatic logic [7:0] pat_byte(input logic [31:0] p, input int i);
      logic [7:0] b;
      case (i)
         0:       b = p[31:24];
         1:       b = p[23:16];
         2:       b = p[15:8];
         3:       b = p[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/lin_slave_frame_receiver.sv @@
// LIN slave receive sequencer: header tracking, identifier filter and frame compare.
//
//   Channel   Direction  Handshake                  Payload
//   req       in         req_valid / req_ready      req_func, req_data_byte
//   rsp       out        rsp_valid / rsp_ready      send_response, frame_done, match_a/b
//   csr       in/out     psel, penable, pwrite      paddr, pwdata, prdata (pready tied high)
//
// Each request advances the sequencer state and the frame buffer at the accepting
// edge, and its result lands in the response register.
// A new request is taken in every cycle while the response register is empty or
// being drained, so a stalled consumer stalls the request side only once it is full.
// Reset (synchronous, active high) returns the sequencer to idle, clears the byte
// count and restores the register defaults; the frame buffer is not cleared.
// Configuration writes land at the access edge and take effect on the next request.
`default_nettype none

module lin_slave_frame_receiver #(
   parameter int FRAME_LEN = lin_rx_pkg::FRAME_LEN_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,
   // request channel
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire                              req_func,
   input  wire  [7:0]                       req_data_byte,
   // response channel
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic                             rsp_send_response,
   output logic                             rsp_frame_done,
   output logic                             rsp_match_a,
   output logic                             rsp_match_b,
   // configuration port
   input  wire                              psel,
   input  wire                              penable,
   input  wire                              pwrite,
   input  wire  [lin_rx_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire  [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);

   // Count holds up to FRAME_LEN-1; index addresses FRAME_LEN entries
   localparam int BL_W  = $clog2(FRAME_LEN);
   localparam int IDX_W = $clog2(FRAME_LEN);

   // ---------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------
   logic [7:0]  response_id_ff;
   logic [7:0]  fixture_id_ff;
   logic [31:0] pattern_a_ff;
   logic [31:0] pattern_b_ff;
   logic        csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         response_id_ff <= lin_rx_pkg::RESPONSE_ID_RST;
         fixture_id_ff  <= lin_rx_pkg::FIXTURE_ID_RST;
         pattern_a_ff   <= lin_rx_pkg::PATTERN_A_RST;
         pattern_b_ff   <= lin_rx_pkg::PATTERN_B_RST;
      end else if (csr_write) begin
         case (paddr[3:2])
            lin_rx_pkg::REG_RESPONSE_ID: response_id_ff <= pwdata[7:0];
            lin_rx_pkg::REG_FIXTURE_ID:  fixture_id_ff  <= pwdata[7:0];
            lin_rx_pkg::REG_PATTERN_A:   pattern_a_ff   <= pwdata;
            lin_rx_pkg::REG_PATTERN_B:   pattern_b_ff   <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         lin_rx_pkg::REG_RESPONSE_ID: prdata = {24'h0, response_id_ff};
         lin_rx_pkg::REG_FIXTURE_ID:  prdata = {24'h0, fixture_id_ff};
         lin_rx_pkg::REG_PATTERN_A:   prdata = pattern_a_ff;
         lin_rx_pkg::REG_PATTERN_B:   prdata = pattern_b_ff;
         default:                     prdata = 32'h0;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Sequencer state
   // ---------------------------------------------------------------------------
   lin_rx_pkg::phase_type phase_ff, phase_in;
   logic [BL_W-1:0]       bytes_left_ff, bytes_left_in;
   logic [7:0]            frame_ff [FRAME_LEN];
   logic [7:0]            frame_in [FRAME_LEN];

   logic                  rsp_valid_ff;
   logic                  send_ff, done_ff, match_a_ff, match_b_ff;
   logic                  send_in, done_in, match_a_in, match_b_in;

   logic                  req_fire;
   logic [7:0]            id_a, id_b;
   logic [BL_W-1:0]       bytes_left_dec;
   logic [BL_W:0]         wr_pos;
   logic [IDX_W-1:0]      wr_idx;
   logic                  id_is_pattern;

   // Accept while the response register is empty or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   assign id_a           = lin_rx_pkg::pat_byte(pattern_a_ff, 0);
   assign id_b           = lin_rx_pkg::pat_byte(pattern_b_ff, 0);
   assign bytes_left_dec = bytes_left_ff - BL_W'(1);
   assign wr_pos         = (BL_W+1)'(FRAME_LEN) - {1'b0, bytes_left_ff};
   assign wr_idx         = wr_pos[IDX_W-1:0];
   // Store data bytes only while the held identifier still names a pattern
   assign id_is_pattern  = (frame_ff[0] == id_a) || (frame_ff[0] == id_b);

   // Next state and frame buffer contents
   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      for (int i = 0; i < FRAME_LEN; i++) begin
         frame_in[i] = frame_ff[i];
      end
      if (req_func) begin
         // break at any time rearms the header
         bytes_left_in = '0;
         phase_in      = lin_rx_pkg::PH_BREAK;
      end else begin
         case (phase_ff)
            lin_rx_pkg::PH_IDLE: ;
            lin_rx_pkg::PH_BREAK: begin
               // drop the framing byte of the break
               bytes_left_in = '0;
               phase_in      = lin_rx_pkg::PH_SYNC;
            end
            lin_rx_pkg::PH_SYNC: begin
               phase_in = (req_data_byte == lin_rx_pkg::SYNC_BYTE) ?
                          lin_rx_pkg::PH_ID : lin_rx_pkg::PH_IDLE;
            end
            lin_rx_pkg::PH_ID: begin
               if (req_data_byte == fixture_id_ff || req_data_byte == response_id_ff) begin
                  phase_in = lin_rx_pkg::PH_IDLE;
               end
               // pattern identifier wins over a response match
               if (req_data_byte == id_a || req_data_byte == id_b) begin
                  frame_in[0]   = req_data_byte;
                  bytes_left_in = BL_W'(FRAME_LEN - 1);
                  phase_in      = lin_rx_pkg::PH_DATA;
               end
            end
            lin_rx_pkg::PH_DATA: begin
               if (bytes_left_ff == '0 || {1'b0, bytes_left_ff} >= (BL_W+1)'(FRAME_LEN)) begin
                  bytes_left_in = '0;
                  phase_in      = lin_rx_pkg::PH_IDLE;
               end else begin
                  if (id_is_pattern) begin
                     for (int i = 1; i < FRAME_LEN; i++) begin
                        if (wr_idx == IDX_W'(i)) begin
                           frame_in[i] = req_data_byte;
                        end
                     end
                  end
                  bytes_left_in = bytes_left_dec;
                  if (bytes_left_dec == '0) begin
                     phase_in = lin_rx_pkg::PH_IDLE;
                  end
               end
            end
            default: begin
               bytes_left_in = '0;
               phase_in      = lin_rx_pkg::PH_IDLE;
            end
         endcase
      end
   end

   // Result fields for this request
   always_comb begin
      send_in    = 1'b0;
      done_in    = 1'b0;
      match_a_in = 1'b0;
      match_b_in = 1'b0;
      if (!req_func) begin
         case (phase_ff)
            lin_rx_pkg::PH_ID: begin
               send_in = (req_data_byte == fixture_id_ff) ||
                         (req_data_byte == response_id_ff);
            end
            lin_rx_pkg::PH_DATA: begin
               if (bytes_left_ff == BL_W'(1)) begin
                  // compare the frame including the byte arriving now
                  done_in    = 1'b1;
                  match_a_in = 1'b1;
                  match_b_in = 1'b1;
                  for (int i = 0; i < FRAME_LEN; i++) begin
                     if (frame_in[i] != lin_rx_pkg::pat_byte(pattern_a_ff, i)) begin
                        match_a_in = 1'b0;
                     end
                     if (frame_in[i] != lin_rx_pkg::pat_byte(pattern_b_ff, i)) begin
                        match_b_in = 1'b0;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= lin_rx_pkg::PH_IDLE;
         bytes_left_ff <= '0;
      end else if (req_fire) begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

   // Frame buffer holds payload only: no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < FRAME_LEN; i++) begin
            frame_ff[i] <= frame_in[i];
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         send_ff    <= send_in;
         done_ff    <= done_in;
         match_a_ff <= match_a_in;
         match_b_ff <= match_b_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_send_response = send_ff;
   assign rsp_frame_done    = done_ff;
   assign rsp_match_a       = match_a_ff;
   assign rsp_match_b       = match_b_ff;

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   a_done_not_send: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> !send_ff)
      else $error("frame completion and response request in one result");

   a_match_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (match_a_ff || match_b_ff) |-> done_ff)
      else $error("pattern match reported without a completed frame");

   a_break_rearms: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_func |=> phase_ff == lin_rx_pkg::PH_BREAK && bytes_left_ff == '0)
      else $error("break did not rearm the header");

   a_count_only_in_data: assert property (@(posedge clock) disable iff (reset)
      phase_ff != lin_rx_pkg::PH_DATA |-> bytes_left_ff == '0)
      else $error("byte count left over outside frame collection");

endmodule

`default_nettype wire

@@ sim/lin_slave_frame_receiver_test.sv @@
// Self-checking test of the LIN slave frame receiver: directed and random byte streams.
module lin_slave_frame_receiver_test;

   localparam int FRAME_LEN = lin_rx_pkg::FRAME_LEN_DEFAULT;

   // One response: {send_response, frame_done, match_a, match_b}
   typedef struct packed {
      logic send_response;
      logic frame_done;
      logic match_a;
      logic match_b;
   } rx_flags_type;

   // Directed request: break flag, byte, and the response where it is obvious
   typedef struct packed {
      logic         brk;
      logic [7:0]   data_byte;
      logic         known;
      rx_flags_type flags;
   } directed_row_type;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic                              req_func;
   logic [7:0]                        req_data_byte;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic                              rsp_send_response;
   logic                              rsp_frame_done;
   logic                              rsp_match_a;
   logic                              rsp_match_b;
   logic                              psel;
   logic                              penable;
   logic                              pwrite;
   logic [lin_rx_pkg::CSR_ADDR_W-1:0] paddr;
   logic [31:0]                       pwdata;
   logic [31:0]                       prdata;
   logic                              pready;

   // Shadow of the sequencer and of its registers
   lin_rx_pkg::phase_type seq_phase = lin_rx_pkg::PH_IDLE;
   logic [7:0]  seq_store [FRAME_LEN];
   logic [1:0]  seq_left = '0;
   logic [7:0]  cfg_response = lin_rx_pkg::RESPONSE_ID_RST;
   logic [7:0]  cfg_fixture = lin_rx_pkg::FIXTURE_ID_RST;
   logic [31:0] cfg_pattern_a = lin_rx_pkg::PATTERN_A_RST;
   logic [31:0] cfg_pattern_b = lin_rx_pkg::PATTERN_B_RST;

   rx_flags_type pending_flags [$];
   rx_flags_type want_flags;
   int           fail_count = 0;
   int           requests_sent = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           rsp_hold_left = 0;

   // Directed stream, walked in order straight after reset (default registers).
   // Every frame buffer entry has been written by the last row, so no later
   // compare can touch an entry that was never written.
   localparam directed_row_type DIRECTED [26] = '{
      '{1'b0, 8'h00, 1'b1, 4'b0000},   // byte while idle: ignored
      '{1'b1, 8'hFF, 1'b1, 4'b0000},   // break, byte field ignored
      '{1'b0, 8'hFF, 1'b0, 4'b0000},   // framing byte of the break: dropped
      '{1'b0, 8'h54, 1'b0, 4'b0000},   // bad sync: back to idle
      '{1'b0, 8'h42, 1'b1, 4'b0000},   // fixture id while idle: ignored
      '{1'b1, 8'h00, 1'b0, 4'b0000},
      '{1'b0, 8'h00, 1'b0, 4'b0000},
      '{1'b0, 8'h55, 1'b0, 4'b0000},
      '{1'b0, 8'h01, 1'b0, 4'b0000},   // unmatched id: keep waiting for an id
      '{1'b0, 8'h42, 1'b1, 4'b1000},   // fixture id answered
      '{1'b1, 8'h00, 1'b0, 4'b0000},
      '{1'b0, 8'h7F, 1'b0, 4'b0000},
      '{1'b0, 8'h55, 1'b0, 4'b0000},
      '{1'b0, 8'h2E, 1'b1, 4'b1000},   // response id answered
      '{1'b1, 8'h00, 1'b0, 4'b0000},
      '{1'b0, 8'h80, 1'b0, 4'b0000},
      '{1'b0, 8'h55, 1'b0, 4'b0000},
      '{1'b0, 8'hD3, 1'b0, 4'b0000},   // pattern A id: start collecting
      '{1'b0, 8'h44, 1'b0, 4'b0000},
      '{1'b1, 8'h00, 1'b0, 4'b0000},   // break in the middle of a frame
      '{1'b0, 8'h00, 1'b0, 4'b0000},
      '{1'b0, 8'h55, 1'b0, 4'b0000},
      '{1'b0, 8'h14, 1'b0, 4'b0000},   // pattern B id
      '{1'b0, 8'hFD, 1'b0, 4'b0000},
      '{1'b0, 8'hFF, 1'b0, 4'b0000},
      '{1'b0, 8'h02, 1'b1, 4'b0101}    // last byte: frame equals pattern B
   };

   lin_slave_frame_receiver #(.FRAME_LEN(FRAME_LEN)) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_send_response (rsp_send_response),
      .rsp_frame_done    (rsp_frame_done),
      .rsp_match_a       (rsp_match_a),
      .rsp_match_b       (rsp_match_b),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs on either handshake
   initial begin
      #400000;
      $display("== FAIL ==");
      $finish;
   end

   // Compare the collected frame with a pattern; bytes beyond the fourth are zero
   function automatic logic store_matches(input logic [31:0] p);
      logic [7:0] want;
      for (int i = 0; i < FRAME_LEN; i++) begin
         want = (i < 4) ? p[31 - 8*i -: 8] : 8'h00;
         if (seq_store[i] !== want)
            return 1'b0;
      end
      return 1'b1;
   endfunction

   // Advance the shadow sequencer by one accepted request and return its flags
   function automatic rx_flags_type advance_sequencer(input logic brk, input logic [7:0] b);
      rx_flags_type r;
      logic [7:0]   id_a;
      logic [7:0]   id_b;
      r = '0;
      id_a = cfg_pattern_a[31:24];
      id_b = cfg_pattern_b[31:24];
      if (brk) begin
         // a break re-arms from any phase
         seq_left = '0;
         seq_phase = lin_rx_pkg::PH_BREAK;
      end else begin
         case (seq_phase)
            lin_rx_pkg::PH_BREAK: begin
               seq_left = '0;
               seq_phase = lin_rx_pkg::PH_SYNC;
            end
            lin_rx_pkg::PH_SYNC: seq_phase = (b == lin_rx_pkg::SYNC_BYTE) ?
                                             lin_rx_pkg::PH_ID : lin_rx_pkg::PH_IDLE;
            lin_rx_pkg::PH_ID: begin
               if (b == cfg_fixture || b == cfg_response) begin
                  r.send_response = 1'b1;
                  seq_phase = lin_rx_pkg::PH_IDLE;
               end
               // a pattern id wins over the answer and still opens a frame
               if (b == id_a || b == id_b) begin
                  seq_store[0] = b;
                  seq_left = 2'(FRAME_LEN - 1);
                  seq_phase = lin_rx_pkg::PH_DATA;
               end
            end
            lin_rx_pkg::PH_DATA: begin
               if (seq_left == 0) begin
                  seq_phase = lin_rx_pkg::PH_IDLE;
               end else begin
                  // store only while the held id is still one of the pattern ids
                  if (seq_store[0] == id_a || seq_store[0] == id_b)
                     seq_store[FRAME_LEN - int'(seq_left)] = b;
                  seq_left = seq_left - 2'd1;
                  if (seq_left == 0) begin
                     r.frame_done = 1'b1;
                     r.match_a = store_matches(cfg_pattern_a);
                     r.match_b = store_matches(cfg_pattern_b);
                     seq_phase = lin_rx_pkg::PH_IDLE;
                  end
               end
            end
            default: begin
               seq_left = '0;
               seq_phase = lin_rx_pkg::PH_IDLE;
            end
         endcase
      end
      return r;
   endfunction

   // Offer one request, hold it until taken, then queue the flags it must produce
   task automatic offer_byte(input logic brk, input logic [7:0] b,
                             input logic known = 1'b0, input rx_flags_type flags = '0);
      rx_flags_type predicted;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_func <= brk;
      req_data_byte <= b;
      do @(posedge clock); while (!(req_valid && req_ready));
      predicted = advance_sequencer(brk, b);
      pending_flags.push_back(known ? flags : predicted);
      requests_sent++;
   endtask

   // Stop offering and wait until every outstanding response has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_flags.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write one register, read it back, and update the shadow copy
   task automatic set_register(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] readback;
      logic [31:0] stored;
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         lin_rx_pkg::REG_RESPONSE_ID: cfg_response = value[7:0];
         lin_rx_pkg::REG_FIXTURE_ID:  cfg_fixture = value[7:0];
         lin_rx_pkg::REG_PATTERN_A:   cfg_pattern_a = value;
         lin_rx_pkg::REG_PATTERN_B:   cfg_pattern_b = value;
         default: ;
      endcase
      stored = (idx == lin_rx_pkg::REG_RESPONSE_ID || idx == lin_rx_pkg::REG_FIXTURE_ID) ?
               {24'h0, value[7:0]} : value;
      @(posedge clock);
      psel <= 1'b1;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      if (readback !== stored) begin
         $error("prdata at 0x%0h: expected %h, got %h", {idx, 2'b00}, stored, readback);
         fail_count++;
      end
   endtask

   task automatic load_settings(input logic [7:0] resp_id, input logic [7:0] fix_id,
                                input logic [31:0] pat_a, input logic [31:0] pat_b);
      set_register(lin_rx_pkg::REG_RESPONSE_ID, {24'h0, resp_id});
      set_register(lin_rx_pkg::REG_FIXTURE_ID, {24'h0, fix_id});
      set_register(lin_rx_pkg::REG_PATTERN_A, pat_a);
      set_register(lin_rx_pkg::REG_PATTERN_B, pat_b);
   endtask

   // One random stretch of traffic: mostly a full header and frame, sometimes line noise
   task automatic random_attempt();
      logic [7:0]  id;
      logic [7:0]  b;
      logic [31:0] frame;
      if ($urandom_range(99) < 15) begin
         repeat ($urandom_range(1, 3))
            offer_byte($urandom_range(3) == 0, 8'($urandom_range(255)));
         return;
      end
      offer_byte(1'b1, 8'($urandom_range(255)));
      offer_byte(1'b0, 8'($urandom_range(255)));
      offer_byte(1'b0, ($urandom_range(9) == 0) ? 8'($urandom_range(255)) :
                                                   lin_rx_pkg::SYNC_BYTE);
      // now and then a stray identifier before the real one
      if ($urandom_range(7) == 0)
         offer_byte(1'b0, 8'($urandom_range(255)));
      case ($urandom_range(5))
         0:       id = cfg_response;
         1:       id = cfg_fixture;
         2, 3:    id = cfg_pattern_a[31:24];
         4:       id = cfg_pattern_b[31:24];
         default: id = 8'($urandom_range(255));
      endcase
      offer_byte(1'b0, id);
      if (seq_phase != lin_rx_pkg::PH_DATA)
         return;
      frame = (seq_store[0] == cfg_pattern_a[31:24]) ? cfg_pattern_a : cfg_pattern_b;
      for (int n = 1; n < FRAME_LEN; n++) begin
         if ($urandom_range(15) == 0) begin
            // abort the frame with a fresh break
            offer_byte(1'b1, 8'($urandom_range(255)));
            return;
         end
         b = (n < 4) ? frame[31 - 8*n -: 8] : 8'h00;
         if ($urandom_range(4) == 0)
            b = b ^ (8'h01 << $urandom_range(7));
         offer_byte(1'b0, b);
      end
   endtask

   // Response side: check each accepted response, then choose the next ready
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_flags.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want_flags = pending_flags.pop_front();
               if (rsp_send_response !== want_flags.send_response) begin
                  $error("send_response: expected %0b, got %0b",
                         want_flags.send_response, rsp_send_response);
                  fail_count++;
               end
               if (rsp_frame_done !== want_flags.frame_done) begin
                  $error("frame_done: expected %0b, got %0b",
                         want_flags.frame_done, rsp_frame_done);
                  fail_count++;
               end
               if (rsp_match_a !== want_flags.match_a) begin
                  $error("match_a: expected %0b, got %0b", want_flags.match_a, rsp_match_a);
                  fail_count++;
               end
               if (rsp_match_b !== want_flags.match_b) begin
                  $error("match_b: expected %0b, got %0b", want_flags.match_b, rsp_match_b);
                  fail_count++;
               end
            end
         end
         // a long hold-off lets the response register fill and back up the requests
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      int          base;
      logic [31:0] pat;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = 1'b0;
      req_data_byte = 8'h00;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed stream against the reset register values
      send_idle_pct = 37;
      recv_idle_pct = 72;
      foreach (DIRECTED[i])
         offer_byte(DIRECTED[i].brk, DIRECTED[i].data_byte, DIRECTED[i].known,
                    DIRECTED[i].flags);
      drain_results();

      // Random phases: receiver-heavy idling, then sender-heavy, then none
      for (int p = 0; p < 6; p++) begin
         send_idle_pct = (p < 2) ? 37 : (p < 4) ? 72 : 0;
         recv_idle_pct = (p < 2) ? 72 : (p < 4) ? 37 : 0;
         case (p)
            1: begin
               // extremes; pattern A id doubles as the response id
               load_settings(8'h00, 8'hFF, 32'h0000_0000, 32'hFFFF_FFFF);
               rsp_hold_left = 60;
            end
            2: load_settings(8'hFF, 8'h00, 32'hFFFF_FFFF, 32'h0000_0000);
            3: begin
               // identical patterns, both ids also answered; the frame left open
               // below loses its stores since the held id no longer matches
               load_settings(8'h3C, 8'hC3, 32'h3C11_2233, 32'h3C11_2233);
               repeat (FRAME_LEN - 2)
                  offer_byte(1'b0, 8'($urandom_range(255)));
               rsp_hold_left = 60;
            end
            4: load_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                             $urandom, $urandom);
            5: begin
               pat = $urandom;
               load_settings(8'($urandom_range(255)), pat[31:24], pat, $urandom);
            end
            default: ;
         endcase
         base = requests_sent;
         while (requests_sent - base < 65)
            random_attempt();
         if (p == 2) begin
            // leave a frame half collected across the next register change
            offer_byte(1'b1, 8'h00);
            offer_byte(1'b0, 8'h00);
            offer_byte(1'b0, lin_rx_pkg::SYNC_BYTE);
            offer_byte(1'b0, cfg_pattern_a[31:24]);
            offer_byte(1'b0, cfg_pattern_a[23:16]);
         end
         drain_results();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_flags.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/lin_rx_pkg.sv
rtl/core/lin_slave_frame_receiver.sv
sim/lin_slave_frame_receiver_test.sv
